### sv/led_grid_delta_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// led_grid_delta_encoder_unit_macros.svh
// Assertion shorthands for the LED grid delta encoder checker.
// ----------------------------------------------------------------------------
`ifndef LED_GRID_DELTA_ENCODER_UNIT_MACROS_SVH
`define LED_GRID_DELTA_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LGDE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LGDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/lgde_pkg.sv
// ----------------------------------------------------------------------------
// lgde_pkg
// Types and constants shared by the LED grid delta encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lgde_pkg;

	localparam logic [1:0] REQ_SET_RGB = 2'd0;
	localparam logic [1:0] REQ_SET_VEL = 2'd1;
	localparam logic [1:0] REQ_TICK    = 2'd2;

	localparam logic KIND_PALETTE = 1'b0;
	localparam logic KIND_RGB     = 1'b1;

	// request coordinates run up to 7, but 4 bits are used internally
	localparam int COORD_W = 4;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] col;
		logic [2:0] row;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [6:0] velocity_in;
	} req_t;

	typedef struct packed {
		logic       cmd_kind;
		logic [7:0] cell_code;
		logic [6:0] red_out;
		logic [6:0] green_out;
		logic [6:0] blue_out;
		logic [6:0] velocity_out;
		logic       last_record;
	} rsp_t;

	// one grid cell; the unused half (velocity or colour) is always zero
	typedef struct packed {
		logic       is_rgb;
		logic [6:0] vel;
		logic [6:0] r;
		logic [6:0] g;
		logic [6:0] b;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

	typedef enum logic {
		OP_SET,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] col;
		logic [2:0] row;
		cell_t      led;
	} qent_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_DRAIN,
		BK_FLUSH
	} bk_state_t;

	// row * 10 + col
	function automatic logic [7:0] cell_code(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		logic [7:0] yy;
		logic [7:0] xx;
		yy = {4'd0, y};
		xx = {4'd0, x};
		return (yy << 3) + (yy << 1) + xx;
	endfunction

	function automatic rsp_t make_rsp(input cell_t c, input logic [7:0] code,
			input logic last);
		rsp_t o;
		o.cmd_kind     = c.is_rgb ? KIND_RGB : KIND_PALETTE;
		o.cell_code    = code;
		o.red_out      = c.r;
		o.green_out    = c.g;
		o.blue_out     = c.b;
		o.velocity_out = c.vel;
		o.last_record  = last;
		return o;
	endfunction

endpackage

`default_nettype wire

### sv/lgde_ram.sv
// ----------------------------------------------------------------------------
// lgde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lgde_ram #(
	parameter  int WIDTH = 29,
	parameter  int DEPTH = 64,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [AW-1:0]            raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### sv/lgde_front.sv
// ----------------------------------------------------------------------------
// lgde_front
// Takes request items, drops those that do nothing, builds the cell value and
// hands the surviving items to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lgde_front #(
	parameter int GRID_WIDTH  = 8,
	parameter int GRID_HEIGHT = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           auto_mode,
	input  wire logic           start,
	output      logic           busy,
	input  wire lgde_pkg::req_t req,
	output      logic           push_valid,
	output      lgde_pkg::qent_t push_ent,
	input  wire logic           push_ready
);

	import lgde_pkg::*;

	logic  s1_valid_q;
	qent_t ent_s1;
	logic  accept;
	logic  in_range;
	logic  keep;
	qent_t ent_new;

	assign busy   = s1_valid_q && !push_ready;
	assign accept = start && !busy;

	assign in_range = ({1'b0, req.col} < COORD_W'(GRID_WIDTH))
		&& ({1'b0, req.row} < COORD_W'(GRID_HEIGHT));

	always_comb begin
		ent_new.op   = (req.req_type == REQ_TICK) ? OP_TICK : OP_SET;
		ent_new.col  = req.col;
		ent_new.row  = req.row;
		ent_new.led  = '0;
		keep         = 1'b0;
		case (req.req_type)
			REQ_SET_RGB: begin
				keep           = in_range;
				ent_new.led.is_rgb = 1'b1;
				ent_new.led.r = req.red_in[7:1];
				ent_new.led.g = req.green_in[7:1];
				ent_new.led.b = req.blue_in[7:1];
			end
			REQ_SET_VEL: begin
				keep             = in_range;
				ent_new.led.vel = req.velocity_in;
			end
			REQ_TICK: begin
				// ticks only matter while batching
				keep = auto_mode;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= keep;
		end else if (push_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1 <= ent_new;
		end
	end

	assign push_valid = s1_valid_q;
	assign push_ent   = ent_s1;

endmodule

`default_nettype wire

### sv/lgde_queue.sv
// ----------------------------------------------------------------------------
// lgde_queue
// Two-entry FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lgde_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	input  wire lgde_pkg::qent_t push_ent,
	output      logic            push_ready,
	output      logic            pop_valid,
	output      lgde_pkg::qent_t pop_ent,
	input  wire logic            pop
);

	import lgde_pkg::*;

	qent_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_ent    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_ent;
		end
	end

endmodule

`default_nettype wire

### sv/lgde_back.sv
// ----------------------------------------------------------------------------
// lgde_back
// Carries out queued items: writes the target and shown grids, and on a tick
// scans the grids one cell per cycle and emits a record per changed cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lgde_back #(
	parameter int GRID_WIDTH  = 8,
	parameter int GRID_HEIGHT = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            auto_mode,
	input  wire logic            q_valid,
	input  wire lgde_pkg::qent_t q_ent,
	output      logic            q_pop,
	output      logic            rsp_strobe,
	output      lgde_pkg::rsp_t  rsp
);

	import lgde_pkg::*;

	localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
	localparam int IDX_W  = (NCELLS > 1) ? $clog2(NCELLS) : 1;

	bk_state_t state_q, state_nxt;

	logic [COORD_W-1:0] cx_q, cy_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic               scan_last;

	logic               s2_valid_q;
	logic [COORD_W-1:0] cx_s2, cy_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic               tgt_vld_s2, shw_vld_s2;

	logic [NCELLS-1:0]  tgt_vld_q, shw_vld_q;

	logic               set_go, tick_go, imm_set;
	logic [IDX_W-1:0]   set_idx;
	logic               tgt_we, shw_we;
	logic [IDX_W-1:0]   shw_waddr;
	cell_t              shw_wdata;
	logic [CELL_W-1:0]  tgt_rdata, shw_rdata;
	cell_t              tgt_cell, shw_cell;
	logic               cmp_diff;

	logic               hold_valid_q;
	rsp_t               hold_q;
	rsp_t               hold_last;
	logic               rsp_strobe_q;
	rsp_t               rsp_q;

	// column-major: index = col * height + row
	assign set_idx = IDX_W'(32'(q_ent.col) * 32'(GRID_HEIGHT) + 32'(q_ent.row));

	assign scan_last = (cx_q == COORD_W'(GRID_WIDTH - 1))
		&& (cy_q == COORD_W'(GRID_HEIGHT - 1));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && q_ent.op == OP_TICK) begin
					state_nxt = BK_ISSUE;
				end
			end
			BK_ISSUE: begin
				if (scan_last) begin
					state_nxt = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				state_nxt = BK_FLUSH;
			end
			BK_FLUSH: begin
				state_nxt = BK_IDLE;
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		q_pop = 1'b0;
		case (state_q)
			BK_IDLE:  q_pop = q_valid;
			default:  q_pop = 1'b0;
		endcase
	end

	assign set_go  = q_pop && (q_ent.op == OP_SET);
	assign tick_go = q_pop && (q_ent.op == OP_TICK);
	assign imm_set = set_go && !auto_mode;

	assign tgt_cell = tgt_vld_s2 ? cell_t'(tgt_rdata) : '0;
	assign shw_cell = shw_vld_s2 ? cell_t'(shw_rdata) : '0;
	assign cmp_diff = s2_valid_q && (tgt_cell != shw_cell);

	assign tgt_we    = set_go;
	assign shw_we    = imm_set || cmp_diff;
	assign shw_waddr = cmp_diff ? idx_s2 : set_idx;
	assign shw_wdata = cmp_diff ? tgt_cell : q_ent.led;

	always_comb begin
		hold_last             = hold_q;
		hold_last.last_record = 1'b1;
	end

	lgde_ram #(
		.WIDTH (CELL_W),
		.DEPTH (NCELLS)
	) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (set_idx),
		.wdata (q_ent.led),
		.raddr (scan_idx_q),
		.rdata (tgt_rdata)
	);

	lgde_ram #(
		.WIDTH (CELL_W),
		.DEPTH (NCELLS)
	) u_shw_ram (
		.clk   (clk),
		.we    (shw_we),
		.waddr (shw_waddr),
		.wdata (shw_wdata),
		.raddr (scan_idx_q),
		.rdata (shw_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			s2_valid_q   <= 1'b0;
			hold_valid_q <= 1'b0;
			rsp_strobe_q <= 1'b0;
			tgt_vld_q    <= '0;
			shw_vld_q    <= '0;
		end else begin
			state_q    <= state_nxt;
			s2_valid_q <= (state_q == BK_ISSUE);
			if (tgt_we) begin
				tgt_vld_q[set_idx] <= 1'b1;
			end
			if (shw_we) begin
				shw_vld_q[shw_waddr] <= 1'b1;
			end
			if (cmp_diff) begin
				hold_valid_q <= 1'b1;
			end else if (state_q == BK_FLUSH) begin
				hold_valid_q <= 1'b0;
			end
			rsp_strobe_q <= imm_set || (cmp_diff && hold_valid_q)
				|| (state_q == BK_FLUSH && hold_valid_q);
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			cx_q       <= '0;
			cy_q       <= '0;
			scan_idx_q <= '0;
		end else if (state_q == BK_ISSUE) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (cy_q == COORD_W'(GRID_HEIGHT - 1)) begin
				cy_q <= '0;
				cx_q <= cx_q + COORD_W'(1);
			end else begin
				cy_q <= cy_q + COORD_W'(1);
			end
		end
		cx_s2      <= cx_q;
		cy_s2      <= cy_q;
		idx_s2     <= scan_idx_q;
		tgt_vld_s2 <= tgt_vld_q[scan_idx_q];
		shw_vld_s2 <= shw_vld_q[scan_idx_q];
		if (cmp_diff) begin
			hold_q <= make_rsp(tgt_cell, cell_code(cx_s2, cy_s2), 1'b0);
		end
		// one record is held back so the final one of a scan can be marked
		if (imm_set) begin
			rsp_q <= make_rsp(q_ent.led,
				cell_code({1'b0, q_ent.col}, {1'b0, q_ent.row}), 1'b1);
		end else if (cmp_diff) begin
			rsp_q <= hold_q;
		end else if (state_q == BK_FLUSH) begin
			rsp_q <= hold_last;
		end
	end

	assign rsp_strobe = rsp_strobe_q;
	assign rsp        = rsp_q;

endmodule

`default_nettype wire

### sv/led_grid_delta_encoder_unit.sv
// ----------------------------------------------------------------------------
// led_grid_delta_encoder_unit
// Keeps a target and a shown LED grid and turns differences into command
// items. An item is taken when start is high and busy is low; a front stage
// drops items that do nothing and feeds a two-entry queue, so busy rises only
// when that queue and the front register are both full. Results appear on rsp
// for one cycle each, marked by rsp_strobe; the receiver cannot stall them.
// A set item, in immediate mode, gives its one record through the front
// register, the queue and the rsp register. A tick in auto mode scans the
// grid through the read ports of the two grid RAMs, one cell per cycle, and
// holds the back end, which takes no other item until the scan is done;
// records come out in column-major order, the last one marked.
// auto_mode is written through cfg_valid/cfg_data and resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module led_grid_delta_encoder_unit #(
	parameter int GRID_WIDTH  = 8,
	parameter int GRID_HEIGHT = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output      logic           busy,
	input  wire lgde_pkg::req_t req,
	input  wire logic           cfg_valid,
	output      logic           cfg_ready,
	input  wire logic           cfg_data,
	output      logic           rsp_strobe,
	output      lgde_pkg::rsp_t rsp
);

	import lgde_pkg::*;

	logic  auto_mode_q;
	logic  push_valid, push_ready;
	qent_t push_ent;
	logic  pop_valid, pop;
	qent_t pop_ent;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			auto_mode_q <= cfg_data;
		end
	end

	lgde_front #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.auto_mode  (auto_mode_q),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.push_valid (push_valid),
		.push_ent   (push_ent),
		.push_ready (push_ready)
	);

	lgde_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ent   (push_ent),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_ent    (pop_ent),
		.pop        (pop)
	);

	lgde_back #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.auto_mode  (auto_mode_q),
		.q_valid    (pop_valid),
		.q_ent      (pop_ent),
		.q_pop      (pop),
		.rsp_strobe (rsp_strobe),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

### sv/lgde_checker.sv
// ----------------------------------------------------------------------------
// lgde_checker
// Port-level checks for the LED grid delta encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_grid_delta_encoder_unit_macros.svh"

module lgde_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire logic           rsp_strobe,
	input wire lgde_pkg::rsp_t rsp
);

	import lgde_pkg::*;

	`LGDE_ASSERT_IMPL(a_rgb_no_vel, rsp_strobe && rsp.cmd_kind == KIND_RGB, rsp.velocity_out == 7'd0, "rgb item carries a velocity")
	`LGDE_ASSERT_IMPL(a_pal_no_rgb, rsp_strobe && rsp.cmd_kind == KIND_PALETTE, (rsp.red_out | rsp.green_out | rsp.blue_out) == 7'd0, "palette item carries colour")
	`LGDE_ASSERT_IMPL(a_code_range, rsp_strobe, rsp.cell_code < 8'd100, "cell code out of range")
	`LGDE_ASSERT_IMPL(a_busy_cause, $rose(busy), $past(start), "busy rose without a new item")

endmodule

bind led_grid_delta_encoder_unit lgde_checker u_lgde_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.rsp_strobe (rsp_strobe),
	.rsp        (rsp)
);

`default_nettype wire
